// ===== src/shortest_process_next_scheduler_macros.svh =====
// assertion macros for the scheduler
`ifndef SHORTEST_PROCESS_NEXT_SCHEDULER_MACROS_SVH
`define SHORTEST_PROCESS_NEXT_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
`define SPN_ASSERT_SAME(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");
`define SPN_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");
`else
`define SPN_ASSERT_SAME(lbl, ant, con)
`define SPN_ASSERT_NEXT(lbl, ant, con)
`endif

`endif

// ===== src/spn_pkg.sv =====
package spn_pkg;

  localparam int ID_W              = 4;
  localparam int DUR_IN_W          = 8;
  localparam int NUM_IDS_DEF       = 16;
  localparam int DURATION_BITS_DEF = 8;

  localparam logic CMD_REQUEST  = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  typedef struct packed {
    logic                command;
    logic [ID_W-1:0]     proc_id;
    logic [DUR_IN_W-1:0] duration;
  } in_item_t;

  typedef struct packed {
    logic            granted;
    logic [ID_W-1:0] granted_id;
    logic            busy_res;
    logic            error;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

endpackage

// ===== src/spn_cell.sv =====
module spn_cell import spn_pkg::*; #(
  parameter int DurW   = DURATION_BITS_DEF,
  parameter int IdxW   = 4,
  parameter int CellId = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic            clr_en,
  input  logic [DurW-1:0] wr_dur,
  input  logic            found_in,
  input  logic [IdxW-1:0] id_in,
  input  logic [DurW-1:0] dur_in,
  output logic            found_out,
  output logic [IdxW-1:0] id_out,
  output logic [DurW-1:0] dur_out
);

  logic            valid_r;
  logic [DurW-1:0] dur_r;
  logic            found_r;
  logic [IdxW-1:0] id_r;
  logic [DurW-1:0] best_r;
  logic            take;

  // this entry beats the candidate only on strictly smaller duration
  assign take = valid_r && (!found_in || (dur_r < dur_in));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r <= 1'b1;
      end else if (clr_en) begin
        valid_r <= 1'b0;
      end
      found_r <= found_in || take;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dur_r <= wr_dur;
    end
    if (take) begin
      id_r   <= IdxW'(CellId);
      best_r <= dur_r;
    end else begin
      id_r   <= id_in;
      best_r <= dur_in;
    end
  end

  assign found_out = found_r;
  assign id_out    = id_r;
  assign dur_out   = best_r;

endmodule

// ===== src/shortest_process_next_scheduler.sv =====
// a request, or a complete while idle, gives its result in the cycle after accept
// a complete while busy gives its result after a scan of the cell chain,
//   the candidate walking the chain one cell per cycle
// throughput: one item at a time; the next item is taken the cycle after the result leaves
// reset: waiting marks cleared at once, processor idle, no clearing pass
module shortest_process_next_scheduler import spn_pkg::*; #(
  parameter int NUM_IDS       = NUM_IDS_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  `include "shortest_process_next_scheduler_macros.svh"

  localparam int IdxW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int CntW = $clog2(NUM_IDS + 1);

  state_t            state_r, state_nxt;
  logic              busy_r, busy_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  out_item_t         out_r, out_nxt;
  logic              wr_go;
  logic              finish;
  logic              in_range;
  logic [DURATION_BITS-1:0] wr_dur;

  logic              found_c [NUM_IDS+1];
  logic [IdxW-1:0]   id_c    [NUM_IDS+1];
  logic [DURATION_BITS-1:0] dur_c [NUM_IDS+1];

  assign in_range    = 32'(in_item.proc_id) < NUM_IDS;
  assign wr_dur      = DURATION_BITS'(in_item.duration);
  assign found_c[0]  = 1'b0;
  assign id_c[0]     = '0;
  assign dur_c[0]    = '0;

  for (genvar i = 0; i < NUM_IDS; i++) begin : g_cell
    logic wr_en;
    logic clr_en;
    assign wr_en  = wr_go && (32'(in_item.proc_id) == i);
    assign clr_en = finish && found_c[NUM_IDS] && (id_c[NUM_IDS] == IdxW'(i));
    spn_cell #(
      .DurW   (DURATION_BITS),
      .IdxW   (IdxW),
      .CellId (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_en),
      .clr_en    (clr_en),
      .wr_dur    (wr_dur),
      .found_in  (found_c[i]),
      .id_in     (id_c[i]),
      .dur_in    (dur_c[i]),
      .found_out (found_c[i+1]),
      .id_out    (id_c[i+1]),
      .dur_out   (dur_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    out_nxt   = out_r;
    wr_go     = 1'b0;
    finish    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          out_nxt   = '0;
          state_nxt = ST_OUT;
          if (in_item.command == CMD_REQUEST) begin
            out_nxt.busy_res = busy_r;
            if (in_range && !busy_r) begin
              busy_nxt           = 1'b1;
              out_nxt.granted    = 1'b1;
              out_nxt.granted_id = in_item.proc_id;
              out_nxt.busy_res   = 1'b1;
            end else if (in_range) begin
              wr_go = 1'b1;
            end
          end else if (!busy_r) begin
            out_nxt.error = 1'b1;
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(NUM_IDS)) begin
          finish    = 1'b1;
          out_nxt   = '0;
          state_nxt = ST_OUT;
          if (found_c[NUM_IDS]) begin
            out_nxt.granted    = 1'b1;
            out_nxt.granted_id = ID_W'(id_c[NUM_IDS]);
            out_nxt.busy_res   = 1'b1;
          end else begin
            busy_nxt = 1'b0;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_item  = out_r;

  `SPN_ASSERT_SAME(a_err_no_grant, out_valid && out_item.error, !out_item.granted && !busy_r)
  `SPN_ASSERT_NEXT(a_idle_grant, in_valid && !in_stall && !busy_r && in_range && (in_item.command == CMD_REQUEST), out_valid && out_item.granted && busy_r)
  `SPN_ASSERT_NEXT(a_empty_idle, finish && !found_c[NUM_IDS], !busy_r && out_valid && !out_item.granted)
  `SPN_ASSERT_SAME(a_busy_match, out_valid, out_item.busy_res == busy_r)

endmodule

// ===== bench/shortest_process_next_scheduler_tb.sv =====
module shortest_process_next_scheduler_tb import spn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_AT     = 900;
  localparam int HOLD_LEN    = 300;
  localparam int SETTLE      = 2 * (NUM_IDS_DEF + 2);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  in_item_t  job_q[$];
  out_item_t decision_q[$];

  // scheduler state as seen from outside
  logic                wait_mark [NUM_IDS_DEF];
  logic [DUR_IN_W-1:0] wait_dur  [NUM_IDS_DEF];
  logic                cpu_busy;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          items_taken = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;
  int          mismatches = 0;

  shortest_process_next_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  function automatic out_item_t predict_decision(in_item_t it);
    out_item_t       res;
    logic            found;
    logic [ID_W-1:0] best;
    res = '0;
    found = 1'b0;
    best = '0;
    if (it.command == CMD_REQUEST) begin
      if (!cpu_busy) begin
        cpu_busy = 1'b1;
        res.granted = 1'b1;
        res.granted_id = it.proc_id;
      end else begin
        wait_mark[it.proc_id] = 1'b1;
        wait_dur[it.proc_id] = it.duration;
      end
    end else if (!cpu_busy) begin
      res.error = 1'b1;
    end else begin
      // strict compare in ascending order keeps the lowest id on ties
      for (int i = 0; i < NUM_IDS_DEF; i++) begin
        if (wait_mark[i] && (!found || wait_dur[i] < wait_dur[best])) begin
          found = 1'b1;
          best = i[ID_W-1:0];
        end
      end
      if (found) begin
        wait_mark[best] = 1'b0;
        res.granted = 1'b1;
        res.granted_id = best;
      end else begin
        cpu_busy = 1'b0;
      end
    end
    res.busy_res = cpu_busy;
    return res;
  endfunction

  // bursts with a varying mix so the waiting table fills and empties
  task automatic queue_random_jobs(input int count);
    in_item_t    it;
    int unsigned complete_pct;
    complete_pct = 40;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: complete_pct = 20;
          1: complete_pct = 40;
          default: complete_pct = 60;
        endcase
      end
      it.command  = ($urandom_range(0, 99) < complete_pct) ? CMD_COMPLETE : CMD_REQUEST;
      it.proc_id  = ID_W'($urandom_range(0, NUM_IDS_DEF - 1));
      it.duration = ($urandom_range(0, 3) == 0) ? DUR_IN_W'($urandom_range(0, 3))
                                                : DUR_IN_W'($urandom_range(0, 255));
      job_q.push_back(it);
    end
  endtask

  task automatic drain();
    while (job_q.size() != 0 || in_valid || decision_q.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    in_item_t nxt_item;
    logic     nxt_valid;
    nxt_item = in_item;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decision_q.push_back(predict_decision(in_item));
        items_taken <= items_taken + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && job_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_item = job_q.pop_front();
      end
    end else begin
      nxt_valid = 1'b0;
    end
    in_valid <= nxt_valid;
    in_item <= nxt_item;
  end

  // receiver stall, with one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decision_q.size() == 0) begin
        $error("result item with no item outstanding");
        mismatches++;
      end else begin
        want = decision_q.pop_front();
        if (out_item.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, out_item.granted);
          mismatches++;
        end
        if (out_item.granted_id !== want.granted_id) begin
          $error("granted_id: expected %0d, got %0d", want.granted_id, out_item.granted_id);
          mismatches++;
        end
        if (out_item.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_item.busy_res);
          mismatches++;
        end
        if (out_item.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, out_item.error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NUM_IDS_DEF; i++) begin
      wait_mark[i] = 1'b0;
      wait_dur[i] = '0;
    end
    cpu_busy = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 6;
    recv_idle_pct = 85;
    // complete while idle, then ties, overwrite and the running id waiting
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'hF, 8'hFF});
    job_q.push_back(in_item_t'{CMD_REQUEST,  4'h0, 8'hFF});
    job_q.push_back(in_item_t'{CMD_REQUEST,  4'h0, 8'h07});
    job_q.push_back(in_item_t'{CMD_REQUEST,  4'hF, 8'h00});
    job_q.push_back(in_item_t'{CMD_REQUEST,  4'h5, 8'h00});
    job_q.push_back(in_item_t'{CMD_REQUEST,  4'h3, 8'hFF});
    job_q.push_back(in_item_t'{CMD_REQUEST,  4'h3, 8'h00});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'hA, 8'h5A});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'h0, 8'h00});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'hF, 8'hFF});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'h5, 8'hA5});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'h0, 8'h00});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'h0, 8'h00});
    job_q.push_back(in_item_t'{CMD_REQUEST,  4'hF, 8'hFF});
    job_q.push_back(in_item_t'{CMD_REQUEST,  4'hF, 8'hFF});
    job_q.push_back(in_item_t'{CMD_REQUEST,  4'h0, 8'hFF});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'h0, 8'h00});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'h0, 8'h00});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'h0, 8'h00});
    job_q.push_back(in_item_t'{CMD_COMPLETE, 4'h0, 8'h00});
    queue_random_jobs(410);
    drain();

    send_idle_pct = 85;
    recv_idle_pct = 6;
    queue_random_jobs(410);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_jobs(420);
    drain();

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
